>>> src/kbt_pkg.sv
`default_nettype none

package kbt_pkg;

    // field widths of the request and response
    localparam int FUNC_W    = 2;
    localparam int KEY_W     = 16;
    localparam int FID_W     = 8;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 8;

    // default geometry of the table
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int KEY_BITS_DEF    = 16;

    // operation codes
    localparam logic [FUNC_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] OP_BIND   = 2'd1;
    localparam logic [FUNC_W-1:0] OP_UNBIND = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_BOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_INVALID   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_META   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CTLX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ABORT  = 2'd3;

    // prefix id reset values
    localparam logic [FID_W-1:0] META_RESET   = 8'd1;
    localparam logic [FID_W-1:0] CTLX_RESET   = 8'd2;
    localparam logic [FID_W-1:0] REPEAT_RESET = 8'd3;
    localparam logic [FID_W-1:0] ABORT_RESET  = 8'd4;

    // no function bound
    localparam logic [FID_W-1:0] FID_NONE = 8'd0;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key_code;
        logic [FID_W-1:0]  function_id;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FID_W-1:0]    bound_function;
        logic [COUNT_W-1:0]  entry_count;
    } rsp_t;

endpackage

`default_nettype wire

>>> src/kbt_mem.sv
`default_nettype none

module kbt_mem #(
    parameter int DEPTH = kbt_pkg::TABLE_DEPTH_DEF,
    parameter int WIDTH = kbt_pkg::KEY_BITS_DEF + kbt_pkg::FID_W
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> src/kbt_cfg.sv
`default_nettype none

module kbt_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [kbt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kbt_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic [kbt_pkg::FID_W-1:0]      fid,
    output logic                                is_prefix
);

    logic [kbt_pkg::FID_W-1:0] meta_reg;
    logic [kbt_pkg::FID_W-1:0] ctlx_reg;
    logic [kbt_pkg::FID_W-1:0] repeat_reg;
    logic [kbt_pkg::FID_W-1:0] abort_reg;

    // writes are always taken
    assign cfg_ready = 1'b1;

    // prefix id registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_reg   <= kbt_pkg::META_RESET;
            ctlx_reg   <= kbt_pkg::CTLX_RESET;
            repeat_reg <= kbt_pkg::REPEAT_RESET;
            abort_reg  <= kbt_pkg::ABORT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                kbt_pkg::REG_META:   meta_reg   <= cfg_data;
                kbt_pkg::REG_CTLX:   ctlx_reg   <= cfg_data;
                kbt_pkg::REG_REPEAT: repeat_reg <= cfg_data;
                kbt_pkg::REG_ABORT:  abort_reg  <= cfg_data;
                default:             meta_reg   <= meta_reg;
            endcase
        end
    end

    // function id names one of the prefixes
    assign is_prefix = (fid == meta_reg) || (fid == ctlx_reg) ||
                       (fid == repeat_reg) || (fid == abort_reg);

endmodule

`default_nettype wire

>>> src/kbt_ctrl.sv
`default_nettype none

module kbt_ctrl #(
    parameter int TABLE_DEPTH = kbt_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = kbt_pkg::KEY_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire kbt_pkg::req_t                          in_req,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output kbt_pkg::rsp_t                               out_rsp,
    output logic [kbt_pkg::FID_W-1:0]                   req_fid,
    input  wire logic                                   is_prefix,
    output logic                                        wr_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]              wr_addr,
    output logic [KEY_BITS+kbt_pkg::FID_W-1:0]          wr_data,
    output logic [$clog2(TABLE_DEPTH)-1:0]              rd_addr,
    input  wire logic [KEY_BITS+kbt_pkg::FID_W-1:0]     rd_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int FID_W = kbt_pkg::FID_W;
    localparam int KEY_W = kbt_pkg::KEY_W;
    localparam int CNT_OUT_W = kbt_pkg::COUNT_W;

    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_PCHK  = 3'd2;
    localparam logic [2:0] S_PMOVE = 3'd3;
    localparam logic [2:0] S_UNWR  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                  state_reg,   state_next;
    logic [kbt_pkg::FUNC_W-1:0]  op_reg,      op_next;
    logic [KEY_BITS-1:0]         key_reg,     key_next;
    logic [FID_W-1:0]            fid_reg,     fid_next;
    logic [CNT_W-1:0]            cnt_reg,     cnt_next;
    logic [CNT_W-1:0]            scan_reg,    scan_next;
    logic                        chk_reg,     chk_next;
    logic [CNT_W-1:0]            idx_reg,     idx_next;
    logic [IDX_W-1:0]            pos_reg,     pos_next;
    logic [kbt_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [FID_W-1:0]            bound_reg,   bound_next;
    logic                        out_valid_reg, out_valid_next;
    kbt_pkg::rsp_t               out_rsp_reg, out_rsp_next;

    logic [CNT_W-1:0]            rd_addr_c;
    logic [CNT_W-1:0]            wr_addr_c;
    logic [KEY_W+KEY_BITS-1:0]   key_wide;
    logic [KEY_BITS-1:0]         key_in;
    logic [CNT_W+CNT_OUT_W-1:0]  cnt_wide;
    logic [KEY_BITS-1:0]         rd_key;
    logic [FID_W-1:0]            rd_fid;
    logic                        hit_key;
    logic                        hit_fid;
    logic [CNT_W-1:0]            cnt_less;
    logic [CNT_W-1:0]            chk_idx;
    logic [CNT_W-1:0]            idx_inc;

    // key masked or widened to the stored key width
    assign key_wide = {{KEY_BITS{1'b0}}, in_req.key_code};
    assign key_in   = key_wide[KEY_BITS-1:0];
    assign cnt_wide = {{CNT_OUT_W{1'b0}}, cnt_reg};

    assign req_fid  = in_req.function_id;
    assign in_stall = (state_reg != S_IDLE);

    // fields of the entry read last cycle
    assign rd_key   = rd_data[KEY_BITS+FID_W-1:FID_W];
    assign rd_fid   = rd_data[FID_W-1:0];
    assign hit_key  = (rd_key == key_reg);
    assign hit_fid  = (rd_fid == fid_reg);
    assign cnt_less = cnt_reg - CNT_ONE;
    assign chk_idx  = scan_reg - CNT_ONE;
    assign idx_inc  = idx_reg + CNT_ONE;

    assign rd_addr  = rd_addr_c[IDX_W-1:0];
    assign wr_addr  = wr_addr_c[IDX_W-1:0];

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        fid_next       = fid_reg;
        cnt_next       = cnt_reg;
        scan_next      = scan_reg;
        chk_next       = chk_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        status_next    = status_reg;
        bound_next     = bound_reg;
        out_valid_next = out_valid_reg;
        out_rsp_next   = out_rsp_reg;
        rd_addr_c      = '0;
        wr_en          = 1'b0;
        wr_addr_c      = cnt_reg;
        wr_data        = {key_reg, fid_reg};

        // response taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                // entry 0 is read ahead for the first compare
                if (in_valid)
                begin
                    op_next     = in_req.func;
                    key_next    = key_in;
                    fid_next    = in_req.function_id;
                    status_next = kbt_pkg::STAT_OK;
                    bound_next  = kbt_pkg::FID_NONE;
                    idx_next    = '0;
                    scan_next   = CNT_ONE;
                    chk_next    = (cnt_reg != '0);
                    case (in_req.func)
                        kbt_pkg::OP_LOOKUP,
                        kbt_pkg::OP_UNBIND:
                        begin
                            state_next = S_SCAN;
                        end
                        kbt_pkg::OP_BIND:
                        begin
                            if (in_req.function_id == kbt_pkg::FID_NONE)
                            begin
                                status_next = kbt_pkg::STAT_INVALID;
                                state_next  = S_DONE;
                            end
                            else if (is_prefix && (cnt_reg != '0))
                            begin
                                state_next = S_PCHK;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // key search, one entry per cycle
                rd_addr_c = scan_reg;
                if (chk_reg && hit_key)
                begin
                    chk_next = 1'b0;
                    case (op_reg)
                        kbt_pkg::OP_LOOKUP:
                        begin
                            bound_next = rd_fid;
                            state_next = S_DONE;
                        end
                        kbt_pkg::OP_BIND:
                        begin
                            wr_en      = 1'b1;
                            wr_addr_c  = chk_idx;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            // fetch the last entry to fill the hole
                            pos_next   = chk_idx[IDX_W-1:0];
                            rd_addr_c  = cnt_less;
                            state_next = S_UNWR;
                        end
                    endcase
                end
                else if (scan_reg < cnt_reg)
                begin
                    scan_next = scan_reg + CNT_ONE;
                    chk_next  = 1'b1;
                end
                else
                begin
                    // key not present
                    chk_next   = 1'b0;
                    state_next = S_DONE;
                    if (op_reg == kbt_pkg::OP_BIND)
                    begin
                        if (cnt_reg >= CNT_FULL)
                        begin
                            status_next = kbt_pkg::STAT_FULL;
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            wr_addr_c = cnt_reg;
                            cnt_next  = cnt_reg + CNT_ONE;
                        end
                    end
                    else
                    begin
                        status_next = kbt_pkg::STAT_NOT_BOUND;
                    end
                end
            end

            S_UNWR:
            begin
                // last entry moves into the hole
                wr_en      = 1'b1;
                wr_addr_c  = CNT_W'(pos_reg);
                wr_data    = rd_data;
                cnt_next   = cnt_less;
                state_next = S_DONE;
            end

            S_PCHK:
            begin
                // entry idx is on the read port
                if (hit_fid)
                begin
                    rd_addr_c  = cnt_less;
                    state_next = S_PMOVE;
                end
                else if (idx_inc < cnt_reg)
                begin
                    rd_addr_c = idx_inc;
                    idx_next  = idx_inc;
                end
                else
                begin
                    rd_addr_c  = '0;
                    scan_next  = CNT_ONE;
                    chk_next   = 1'b1;
                    state_next = S_SCAN;
                end
            end

            S_PMOVE:
            begin
                // old last entry replaces entry idx, then is checked in place
                wr_en     = 1'b1;
                wr_addr_c = idx_reg;
                wr_data   = rd_data;
                cnt_next  = cnt_less;
                scan_next = '0;
                chk_next  = 1'b0;
                if (idx_reg >= cnt_less)
                begin
                    state_next = S_SCAN;
                end
                else if (hit_fid)
                begin
                    if (idx_inc == cnt_less)
                    begin
                        cnt_next   = cnt_reg - CNT_TWO;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        rd_addr_c = cnt_reg - CNT_TWO;
                    end
                end
                else if (idx_inc < cnt_less)
                begin
                    rd_addr_c  = idx_inc;
                    idx_next   = idx_inc;
                    state_next = S_PCHK;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end

            S_DONE:
            begin
                // hand the response to the output register
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next              = 1'b1;
                    out_rsp_next.status         = status_reg;
                    out_rsp_next.bound_function = bound_reg;
                    out_rsp_next.entry_count    = cnt_wide[CNT_OUT_W-1:0];
                    state_next                  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            chk_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            chk_reg       <= chk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        fid_reg     <= fid_next;
        scan_reg    <= scan_next;
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        status_reg  <= status_next;
        bound_reg   <= bound_next;
        out_rsp_reg <= out_rsp_next;
    end

    assign out_valid = out_valid_reg;
    assign out_rsp   = out_rsp_reg;

    // entry count stays within the table
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("entry count beyond table depth");

    // writes only land on live entries or the append slot
    a_wr_addr: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_addr_c <= cnt_reg) && (wr_addr_c < CNT_FULL))
        else $error("table write outside live range");

    // idle sequencer never changes the entry count
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> $stable(cnt_reg))
        else $error("entry count moved while idle");

    // a new response only comes out of the done state
    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_next && !(out_valid_reg && out_stall) && (state_reg != S_DONE))
        |-> (out_valid_reg && out_stall))
        else $error("response loaded outside done state");

endmodule

`default_nettype wire

>>> src/key_binding_table_top.sv
// lookup, unbind and plain bind: a key search over the N live entries, then the response
// prefix bind: a purge pass that drops entries bound to the prefix id, then the key search
// throughput: one request at a time, bounded by one table read per cycle on the memory port
// a finished response waits in the output register while the next request is taken
// reset: entry count cleared, prefix ids back to 1..4, table contents left undefined
`default_nettype none

module key_binding_table_top #(
    parameter int TABLE_DEPTH = kbt_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = kbt_pkg::KEY_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire kbt_pkg::req_t                 in_req,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output kbt_pkg::rsp_t                      out_rsp,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [kbt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [kbt_pkg::CFG_W-1:0]     cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int ENT_W = KEY_BITS + kbt_pkg::FID_W;

    logic [kbt_pkg::FID_W-1:0] req_fid;
    logic                      is_prefix;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic [ENT_W-1:0]          wr_data;
    logic [IDX_W-1:0]          rd_addr;
    logic [ENT_W-1:0]          rd_data;

    // prefix id registers
    kbt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fid       (req_fid),
        .is_prefix (is_prefix)
    );

    // key / function table
    kbt_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENT_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // request sequencer
    kbt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rsp   (out_rsp),
        .req_fid   (req_fid),
        .is_prefix (is_prefix),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

endmodule

`default_nettype wire
